### sv/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg: shared types and constants
// Field widths, register indexes and the queue entry flags of the border
// cell counter.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int CFG_W   = 11;  // grid_rows / grid_cols register width
  localparam int IDX_W   = 4;   // configuration index width
  localparam int CMP_W   = 14;  // width for size compares, holds 4096 + 1
  localparam int COUNT_W = 21;  // border_count width
  localparam int IN_W    = 8;   // s_tdata width
  localparam int OUT_W   = 24;  // m_tdata width

  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] REG_GRID_ROWS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GRID_COLS = IDX_W'(1);

  // cell classification made by the front end
  typedef struct packed {
    logic star;
    logic last_col;
    logic last_row;
    logic row_gt0;
    logic row_ge2;
    logic col_gt0;
    logic col_ge2;
  } cls_t;

endpackage

### sv/grid_border_cell_counter_core.sv
// ----------------------------------------------------------------------------
// grid_border_cell_counter_core: hash cells next to a star, per frame
// Raster grid in, one total out with the frame's last cell.
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+----------------------------------
//  s_*      | in  | s_tvalid/s_tready  | one grid cell per request
//  m_*      | out | m_tvalid/m_tready  | frame total, one per frame
//  cfg_*    | in  | cfg_valid/cfg_ready| size register write
//
// Sustained rate one cell per clock unless the output stalls; each cell needs
// one write and up to two reads of each line store in the back end. A cell
// passes a two-entry queue and is judged as it leaves it; the frame total is
// registered as the last cell is judged. Only the frame's last cell waits on a
// full output register; cells behind it fill the queue, then s_tready drops.
// Reset clears counters, window, total and queue; line stores need no clear.
// ----------------------------------------------------------------------------
module grid_border_cell_counter_core #(
  parameter int MAX_COLS = gbc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gbc_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [gbc_pkg::IN_W-1:0]    s_tdata,   // [0] cell_is_star, rest zero
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [gbc_pkg::OUT_W-1:0]   m_tdata,   // [20:0] border_count, rest zero
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gbc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [gbc_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CWID = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW   = CWID + $bits(gbc_pkg::cls_t);

  logic                        q_full, q_push, q_pop, q_valid;
  gbc_pkg::cls_t               f_cls, b_cls;
  logic [CWID-1:0]             f_col, b_col;
  logic [EW-1:0]               b_entry;
  logic [gbc_pkg::COUNT_W-1:0] border_count;

  assign cfg_ready = 1'b1;

  gbc_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cell_valid(s_tvalid), .cell_is_star(s_tdata[0]), .cell_ready(s_tready),
    .q_full(q_full), .q_push(q_push), .q_cls(f_cls), .q_col(f_col)
  );

  gbc_fifo #(.WIDTH(EW), .DEPTH(gbc_pkg::QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data({f_col, f_cls}), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_data(b_entry)
  );

  assign b_cls = b_entry[$bits(gbc_pkg::cls_t)-1:0];
  assign b_col = b_entry[EW-1:$bits(gbc_pkg::cls_t)];

  gbc_back #(.MAX_COLS(MAX_COLS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_cls(b_cls), .q_col(b_col), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .border_count(border_count)
  );

  assign m_tdata = gbc_pkg::OUT_W'(border_count);

endmodule

### sv/gbc_front.sv
// ----------------------------------------------------------------------------
// gbc_front: input acceptance and cell classification
// Holds the size registers and the raster row / column counters and tags
// each accepted cell with its position flags.
// ----------------------------------------------------------------------------
module gbc_front #(
  parameter int MAX_COLS = gbc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gbc_pkg::DEF_MAX_ROWS,
  localparam int CWID = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RWID = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [gbc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gbc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       cell_valid,
  input  logic                       cell_is_star,
  output logic                       cell_ready,
  input  logic                       q_full,
  output logic                       q_push,
  output gbc_pkg::cls_t              q_cls,
  output logic [CWID-1:0]            q_col
);

  localparam int CW = gbc_pkg::CMP_W;

  logic [gbc_pkg::CFG_W-1:0] grid_rows;
  logic [gbc_pkg::CFG_W-1:0] grid_cols;
  logic [RWID-1:0]           row_pos;
  logic [CWID-1:0]           col_pos;
  logic [CW-1:0]             rows_eff;
  logic [CW-1:0]             cols_eff;
  logic                      last_col;
  logic                      last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= gbc_pkg::CFG_W'(1);
      grid_cols <= gbc_pkg::CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        gbc_pkg::REG_GRID_ROWS: grid_rows <= cfg_data;
        gbc_pkg::REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize reads as the maximum
  always_comb begin
    if (grid_rows == '0)                 rows_eff = CW'(1);
    else if (CW'(grid_rows) > CW'(MAX_ROWS)) rows_eff = CW'(MAX_ROWS);
    else                                 rows_eff = CW'(grid_rows);
    if (grid_cols == '0)                 cols_eff = CW'(1);
    else if (CW'(grid_cols) > CW'(MAX_COLS)) cols_eff = CW'(MAX_COLS);
    else                                 cols_eff = CW'(grid_cols);
  end

  assign last_col = (CW'(col_pos) + CW'(1)) >= cols_eff;
  assign last_row = (CW'(row_pos) + CW'(1)) >= rows_eff;

  assign cell_ready = !q_full;
  assign q_push     = cell_valid && !q_full;
  assign q_col      = col_pos;

  always_comb begin
    q_cls.star     = cell_is_star;
    q_cls.last_col = last_col;
    q_cls.last_row = last_row;
    q_cls.row_gt0  = (row_pos != '0);
    q_cls.row_ge2  = (CW'(row_pos) >= CW'(2));
    q_cls.col_gt0  = (col_pos != '0);
    q_cls.col_ge2  = (CW'(col_pos) >= CW'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (q_push) begin
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : RWID'(CW'(row_pos) + CW'(1));
      end else begin
        col_pos <= CWID'(CW'(col_pos) + CW'(1));
      end
    end
  end

endmodule

### sv/gbc_fifo.sv
// ----------------------------------------------------------------------------
// gbc_fifo: small request queue
// Register-based FIFO between the classifier and the counting back end.
// ----------------------------------------------------------------------------
module gbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gbc_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full     = (fill == NW'(DEPTH));
  assign valid    = (fill != '0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      if (push && !pop)      fill <= NW'(fill + 1'b1);
      else if (pop && !push) fill <= NW'(fill - 1'b1);
    end
  end

endmodule

### sv/gbc_back.sv
// ----------------------------------------------------------------------------
// gbc_back: line stores, neighbor window and running total
// Judges cells against their four neighbors and emits the frame total.
// ----------------------------------------------------------------------------
module gbc_back #(
  parameter int MAX_COLS = gbc_pkg::DEF_MAX_COLS,
  localparam int CWID = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  gbc_pkg::cls_t                q_cls,
  input  logic [CWID-1:0]              q_col,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gbc_pkg::COUNT_W-1:0]  border_count
);

  localparam int NW = gbc_pkg::COUNT_W;

  logic prev_mem [MAX_COLS];
  logic old_mem  [MAX_COLS];

  // lookahead for the next column: raw reads plus same-cycle write bypass
  logic prev_q0, prev_q1, old_q;
  logic byp_pc, byp_pn, byp_oc;
  logic byp_x, byp_above;
  logic pc, pn, oc;

  logic [2:0]    window;  // [0] above-left, [1] left, [2] two to the left
  logic [NW-1:0] total;

  logic          frame_last;
  logic          above;
  logic          inc_up, inc_left, inc_self;
  logic [NW-1:0] total_next;
  logic [CWID-1:0] nxt, nxt1;

  assign pc = byp_pc ? byp_x     : prev_q0;
  assign pn = byp_pn ? byp_x     : prev_q1;
  assign oc = byp_oc ? byp_above : old_q;

  assign frame_last = q_cls.last_row && q_cls.last_col;
  // only a frame-end request needs the output slot
  assign q_pop = q_valid && (!frame_last || !m_tvalid || m_tready);

  always_comb begin
    above = q_cls.row_gt0 && pc;
    // cell directly above, now that its lower neighbor is known
    inc_up = q_cls.row_gt0 && !pc &&
             (q_cls.star || (q_cls.row_ge2 && oc) || (q_cls.col_gt0 && window[0]) ||
              (!q_cls.last_col && pn));
    // last row: left neighbor, now that its right neighbor is known
    inc_left = q_cls.last_row && q_cls.col_gt0 && !window[1] &&
               (q_cls.star || (q_cls.row_gt0 && window[0]) ||
                (q_cls.col_ge2 && window[2]));
    // very last cell judged on arrival
    inc_self = frame_last && !q_cls.star &&
               ((q_cls.row_gt0 && above) || (q_cls.col_gt0 && window[1]));
    total_next = total + NW'(inc_up) + NW'(inc_left) + NW'(inc_self);
    nxt  = q_cls.last_col ? '0 : CWID'(q_col + 1'b1);
    nxt1 = CWID'(nxt + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prev_mem[q_col] <= q_cls.star;
      old_mem[q_col]  <= above;
      prev_q0   <= prev_mem[nxt];
      prev_q1   <= prev_mem[nxt1];
      old_q     <= old_mem[nxt];
      byp_pc    <= (nxt == q_col);
      byp_pn    <= (nxt1 == q_col);
      byp_oc    <= (nxt == q_col);
      byp_x     <= q_cls.star;
      byp_above <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop && frame_last) m_tvalid <= 1'b1;
      else if (m_tready)       m_tvalid <= 1'b0;
      if (q_pop) begin
        window <= q_cls.last_col ? 3'b000 : {window[1], q_cls.star, above};
        if (frame_last) begin
          total <= '0;
        end else begin
          total <= total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && frame_last) border_count <= total_next;
  end

endmodule

### sv/gbc_checker.sv
// ----------------------------------------------------------------------------
// gbc_checker: port-level checks of the border cell counter
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module gbc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [gbc_pkg::OUT_W-1:0] m_tdata,
  input logic                      cfg_ready
);

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // padding above the 21-bit count is zero
  a_out_pad: assert property (@(posedge clk)
    m_tvalid |-> (m_tdata[gbc_pkg::OUT_W-1:gbc_pkg::COUNT_W] == '0))
    else $error("nonzero pad bits in result");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // size writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port stalled");

endmodule

bind grid_border_cell_counter_core gbc_checker u_gbc_checker (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .cfg_ready(cfg_ready)
);

### verif/grid_border_cell_counter_core_test.sv
// ----------------------------------------------------------------------------
// grid_border_cell_counter_core_test: self-checking bench for the border counter
// Streams raster grids of hash and star cells through the core under several
// grid sizes (zero sizes and stray register indexes included) and predicts
// each frame total. Random gaps on both stream sides.
// ----------------------------------------------------------------------------
module grid_border_cell_counter_core_test;

  localparam int GRID_MAX_COLS = gbc_pkg::DEF_MAX_COLS;
  localparam int GRID_MAX_ROWS = gbc_pkg::DEF_MAX_ROWS;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CELLS  = 580;

  typedef enum logic [1:0] {PLAN_CELL, PLAN_WRITE, PLAN_DRAIN} plan_kind_t;

  typedef struct packed {
    plan_kind_t                  kind;
    logic                        star;
    logic [gbc_pkg::IDX_W-1:0]   idx;
    logic [gbc_pkg::CFG_W-1:0]   value;
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [gbc_pkg::IN_W-1:0]      s_tdata   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [gbc_pkg::OUT_W-1:0]     m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [gbc_pkg::IDX_W-1:0]     cfg_index = '0;
  logic [gbc_pkg::CFG_W-1:0]     cfg_data  = '0;

  grid_border_cell_counter_core #(
    .MAX_COLS(GRID_MAX_COLS),
    .MAX_ROWS(GRID_MAX_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  plan_t                           cell_plan[$];
  logic [gbc_pkg::COUNT_W-1:0]     frame_totals_q[$];
  int                              pending_totals = 0;  // registered copy for the driver side
  logic                            plan_drained = 1'b0;
  int                              mismatches = 0;
  int                              cells_sent = 0;
  int                              totals_seen = 0;
  int                              writes_done = 0;

  // stimulus planning state
  int plan_rows = 1;
  int plan_cols = 1;
  int random_cells = 0;

  // predicted block state
  logic [gbc_pkg::CFG_W-1:0]   rows_reg = gbc_pkg::CFG_W'(1);
  logic [gbc_pkg::CFG_W-1:0]   cols_reg = gbc_pkg::CFG_W'(1);
  logic                        two_up_row[GRID_MAX_COLS];
  logic                        one_up_row[GRID_MAX_COLS];
  logic [2:0]                  win = '0;   // [0] up-left, [1] left, [2] two left
  int unsigned                 row_pos = 0;
  int unsigned                 col_pos = 0;
  logic [gbc_pkg::COUNT_W-1:0] border_acc = '0;

  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int quiet = 0;

  initial begin
    for (int i = 0; i < GRID_MAX_COLS; i++) begin
      two_up_row[i] = 1'b0;
      one_up_row[i] = 1'b0;
    end
  end

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int eff_size(input logic [gbc_pkg::CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Judge the neighbors that become known with this cell; returns 1 with the
  // frame total on the frame's last cell.
  function automatic logic judge_cell(input logic star,
                                      output logic [gbc_pkg::COUNT_W-1:0] total);
    int unsigned nrows, ncols, r, c;
    logic last_c, last_r, up, hit;
    nrows = eff_size(rows_reg, GRID_MAX_ROWS);
    ncols = eff_size(cols_reg, GRID_MAX_COLS);
    r = row_pos;
    c = col_pos;
    last_c = (c + 1 >= ncols);
    last_r = (r + 1 >= nrows);
    up = 1'b0;
    total = '0;
    // cell above, now that its lower neighbor is here
    if (r > 0) begin
      up = one_up_row[c];
      if (!up) begin
        hit = star;
        if (r >= 2) hit |= two_up_row[c];
        if (c > 0) hit |= win[0];
        if (!last_c && c + 1 < GRID_MAX_COLS) hit |= one_up_row[c + 1];
        if (hit) border_acc++;
      end
    end
    // bottom row: left neighbor is complete once its right one arrives
    if (last_r && c > 0 && !win[1]) begin
      hit = star;
      if (r > 0) hit |= win[0];
      if (c >= 2) hit |= win[2];
      if (hit) border_acc++;
    end
    // very last cell of the frame
    if (last_r && last_c && !star) begin
      hit = 1'b0;
      if (r > 0) hit |= up;
      if (c > 0) hit |= win[1];
      if (hit) border_acc++;
    end
    two_up_row[c] = up;
    one_up_row[c] = star;
    win = {win[1], star, up};
    if (last_c) begin
      col_pos = 0;
      win = '0;
      if (last_r) begin
        total = border_acc;
        border_acc = '0;
        row_pos = 0;
        return 1'b1;
      end
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    return 1'b0;
  endfunction

  task automatic plan_cell(input logic star);
    plan_t p;
    p = '{kind: PLAN_CELL, star: star, idx: '0, value: '0};
    cell_plan.push_back(p);
  endtask

  task automatic plan_write(input logic [gbc_pkg::IDX_W-1:0] idx,
                            input logic [gbc_pkg::CFG_W-1:0] value);
    plan_t p;
    p = '{kind: PLAN_WRITE, star: 1'b0, idx: idx, value: value};
    cell_plan.push_back(p);
    if (idx == gbc_pkg::REG_GRID_ROWS) plan_rows = eff_size(value, GRID_MAX_ROWS);
    else if (idx == gbc_pkg::REG_GRID_COLS) plan_cols = eff_size(value, GRID_MAX_COLS);
  endtask

  task automatic plan_drain();
    plan_t p;
    p = '{kind: PLAN_DRAIN, star: 1'b0, idx: '0, value: '0};
    cell_plan.push_back(p);
  endtask

  task automatic plan_size(input int rows, input int cols);
    plan_write(gbc_pkg::REG_GRID_ROWS, gbc_pkg::CFG_W'(rows));
    plan_write(gbc_pkg::REG_GRID_COLS, gbc_pkg::CFG_W'(cols));
  endtask

  // star_pct: chance in percent that a cell is a star
  task automatic plan_frame(input int star_pct);
    for (int i = 0; i < plan_rows * plan_cols; i++)
      plan_cell($urandom_range(0, 99) < star_pct);
  endtask

  task automatic plan_pattern(input logic [8:0] bits);
    for (int i = 0; i < 9; i++) plan_cell(bits[i]);
  endtask

  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 80) return $urandom_range(1, 6);
    return $urandom_range(7, 16);
  endfunction

  // driver: walks the plan, writes sizes only once the core has gone quiet
  always @(posedge clk) begin : drive
    logic nxt_valid, nxt_cfg;
    nxt_valid = 1'b0;
    nxt_cfg = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
      send_gap = 0;
      quiet = 0;
    end else begin
      if (s_tvalid && s_tready) cells_sent++;
      if (cfg_valid && cfg_ready) writes_done++;
      if (s_tvalid || m_tvalid || pending_totals != 0) quiet = 0;
      else if (quiet < 1000) quiet++;
      if (!((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready))) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cell_plan.size() > 0) begin
          case (cell_plan[0].kind)
            PLAN_CELL: begin
              s_tdata <= gbc_pkg::IN_W'(cell_plan[0].star);
              nxt_valid = 1'b1;
              void'(cell_plan.pop_front());
              send_gap = pick_gap(send_calm);
            end
            PLAN_WRITE: begin
              if (quiet >= SETTLE_CYCLES) begin
                cfg_index <= cell_plan[0].idx;
                cfg_data <= cell_plan[0].value;
                nxt_cfg = 1'b1;
                void'(cell_plan.pop_front());
              end
            end
            default: begin
              if (quiet >= 2) void'(cell_plan.pop_front());
            end
          endcase
        end
        s_tvalid <= nxt_valid;
        cfg_valid <= nxt_cfg;
      end
      plan_drained <= (cell_plan.size() == 0);
    end
  end

  // monitor: checks totals first, then tracks size writes and accepted cells
  always @(posedge clk) begin : watch
    logic [gbc_pkg::COUNT_W-1:0] want, got;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[gbc_pkg::COUNT_W-1:0];
        totals_seen++;
        if (m_tdata[gbc_pkg::OUT_W-1:gbc_pkg::COUNT_W] !== '0) begin
          $error("m_tdata padding: expected 0, actual %0h",
                 m_tdata[gbc_pkg::OUT_W-1:gbc_pkg::COUNT_W]);
          mismatches++;
        end
        if (frame_totals_q.size() == 0) begin
          $error("border_count: expected none, actual %0d", got);
          mismatches++;
        end else begin
          want = frame_totals_q.pop_front();
          if (got !== want) begin
            $error("border_count: expected %0d, actual %0d", want, got);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gbc_pkg::REG_GRID_ROWS) rows_reg = cfg_data;
        else if (cfg_index == gbc_pkg::REG_GRID_COLS) cols_reg = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (judge_cell(s_tdata[0], want)) frame_totals_q.push_back(want);
      end
      pending_totals <= frame_totals_q.size();
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) recv_stall = pick_gap(recv_calm);
      end
    end
  end

  initial begin : stimulus
    int star_pct;
    int frame_cnt;
    // directed: reset size is one cell, a lone cell never counts
    plan_cell(1'b0);
    plan_cell(1'b1);
    plan_size(0, 0);      // zero sizes act as one
    plan_cell(1'b0);
    plan_write(gbc_pkg::IDX_W'(15), gbc_pkg::CFG_W'(2047));   // stray index, ignored
    plan_size(3, 3);
    plan_pattern(9'b000_010_000);   // star in the middle, four hash neighbors
    plan_pattern(9'b111_101_111);   // hash in the middle ringed by stars
    plan_drain();

    // random sizes, a few frames per size
    while (random_cells < RANDOM_CELLS) begin
      plan_size(pick_dim(), pick_dim());
      if ($urandom_range(0, 9) < 3)
        plan_write(gbc_pkg::IDX_W'($urandom_range(2, 15)),
                   gbc_pkg::CFG_W'($urandom_range(0, 2047)));
      frame_cnt = $urandom_range(1, 3);
      for (int f = 0; f < frame_cnt && random_cells < RANDOM_CELLS; f++) begin
        case ($urandom_range(0, 9))
          0: star_pct = 0;
          1: star_pct = 100;
          default: star_pct = $urandom_range(10, 90);
        endcase
        plan_frame(star_pct);
        random_cells += plan_rows * plan_cols;
        if ($urandom_range(0, 3) == 0) plan_drain();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (!plan_drained || s_tvalid || cfg_valid || pending_totals != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d cells (%0d in random frames) under %0d register writes,",
             cells_sent, random_cells, writes_done);
    $display("checked %0d frame totals; sizes ranged from one cell to 16 by 16.",
             totals_seen);
    if (mismatches == 0) begin
      $display("PASS grid_border_cell_counter_core");
    end else begin
      $display("FAIL grid_border_cell_counter_core");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL grid_border_cell_counter_core");
    $finish;
  end

endmodule
